// ===== src/npg_pkg.sv =====
// Shared constants and interface types for the next-permutation generator.
package npg_pkg;

    localparam int MAX_LEN = 16;
    localparam int IDX_W   = $clog2(MAX_LEN);
    localparam int CNT_W   = IDX_W + 1;
    localparam int DATA_W  = 16;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [DATA_W-1:0] elem_t;

    // element store access from the sequencer
    typedef struct packed {
        logic  we;
        idx_t  waddr;
        elem_t wdata;
        idx_t  raddr;
    } mem_req_t;

    // load request for the output register
    typedef struct packed {
        logic  ld;
        elem_t value;
        logic  has_next;
        logic  last;
    } out_req_t;

endpackage

// ===== src/next_permutation_generator_core.sv =====
// The vector is loaded element by element; after the final element come the pivot
// search, the successor search, the swap and the tail reversal, then one result
// per cycle while the output is not stalled, after a single store read. One vector
// is handled at a time.
// Reset (aresetn low, synchronous) clears the sequencer, element count and output
// valid; the element store is not cleared.
module next_permutation_generator_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] value_in
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] value_out
    output logic [0:0]  m_tuser,   // [0] has_next
    output logic        m_tlast
);
    import npg_pkg::*;

    mem_req_t mem_req;
    elem_t    mem_rdata;
    out_req_t out_req;
    logic     out_free;

    logic  m_valid_reg, m_valid_next;
    elem_t m_data_reg;
    logic  m_user_reg;
    logic  m_last_reg;

    npg_store u_store (
        .aclk  (aclk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    npg_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_value  (s_tdata),
        .in_last   (s_tlast),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata),
        .out_free  (out_free),
        .out_req   (out_req)
    );

    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        if (out_req.ld) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_req.ld) begin
            m_data_reg <= out_req.value;
            m_user_reg <= out_req.has_next;
            m_last_reg <= out_req.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ===== src/npg_store.sv =====
// Element store: one write port, one registered read port.
module npg_store (
    input  logic            aclk,
    input  npg_pkg::mem_req_t req,
    output npg_pkg::elem_t  rdata
);
    import npg_pkg::*;

    elem_t mem [MAX_LEN];
    elem_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/npg_ctrl.sv =====
// Sequencer and shared comparator: load, pivot search, successor search, swap, tail reversal, emit.
module npg_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  npg_pkg::elem_t    in_value,
    input  logic              in_last,
    output npg_pkg::mem_req_t mem_req,
    input  npg_pkg::elem_t    mem_rdata,
    input  logic              out_free,
    output npg_pkg::out_req_t out_req
);
    import npg_pkg::*;

    localparam logic [3:0] ST_LOAD  = 4'd0;
    localparam logic [3:0] ST_SINIT = 4'd1;
    localparam logic [3:0] ST_SFRST = 4'd2;
    localparam logic [3:0] ST_SSCAN = 4'd3;
    localparam logic [3:0] ST_FSCAN = 4'd4;
    localparam logic [3:0] ST_WPIV  = 4'd5;
    localparam logic [3:0] ST_WSUC  = 4'd6;
    localparam logic [3:0] ST_RCHK  = 4'd7;
    localparam logic [3:0] ST_RHI   = 4'd8;
    localparam logic [3:0] ST_RLOV  = 4'd9;
    localparam logic [3:0] ST_RWLO  = 4'd10;
    localparam logic [3:0] ST_RWHI  = 4'd11;
    localparam logic [3:0] ST_ERD   = 4'd12;
    localparam logic [3:0] ST_ELD   = 4'd13;

    logic [3:0] state_reg, state_next;
    cnt_t  cnt_reg, cnt_next;
    idx_t  pos_reg, pos_next;
    idx_t  hi_reg, hi_next;
    idx_t  piv_idx_reg, piv_idx_next;
    elem_t piv_val_reg, piv_val_next;
    elem_t hold_reg, hold_next;
    logic  found_reg, found_next;

    idx_t  last_idx;
    elem_t cmp_a, cmp_b;
    logic  cmp_lt;
    logic  emit_last;

    assign last_idx  = idx_t'(cnt_reg - cnt_t'(1));
    assign emit_last = (cnt_t'({1'b0, pos_reg}) + cnt_t'(1)) == cnt_reg;

    // one comparator shared by the pivot and the successor searches
    always_comb begin
        if (state_reg == ST_FSCAN) begin
            cmp_a = piv_val_reg;
            cmp_b = mem_rdata;
        end else begin
            cmp_a = mem_rdata;
            cmp_b = hold_reg;
        end
    end
    assign cmp_lt = cmp_a < cmp_b;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        pos_next     = pos_reg;
        hi_next      = hi_reg;
        piv_idx_next = piv_idx_reg;
        piv_val_next = piv_val_reg;
        hold_next    = hold_reg;
        found_next   = found_reg;
        in_ready     = 1'b0;
        mem_req      = '{we: 1'b0, waddr: pos_reg, wdata: in_value, raddr: pos_reg};
        out_req      = '{ld: 1'b0, value: mem_rdata, has_next: found_reg, last: emit_last};

        unique case (state_reg)
            ST_LOAD: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (cnt_reg < cnt_t'(MAX_LEN)) begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = cnt_reg[IDX_W-1:0];
                        cnt_next      = cnt_reg + cnt_t'(1);
                    end
                    if (in_last) begin
                        found_next = 1'b0;
                        state_next = ST_SINIT;
                    end
                end
            end
            ST_SINIT: begin
                if (cnt_reg < cnt_t'(2)) begin
                    pos_next   = '0;
                    state_next = ST_ERD;
                end else begin
                    mem_req.raddr = last_idx;
                    pos_next      = last_idx;
                    state_next    = ST_SFRST;
                end
            end
            ST_SFRST: begin
                hold_next     = mem_rdata;
                mem_req.raddr = pos_reg - idx_t'(1);
                state_next    = ST_SSCAN;
            end
            ST_SSCAN: begin
                // mem_rdata is element pos-1, hold_reg is element pos
                if (cmp_lt) begin
                    piv_idx_next  = pos_reg - idx_t'(1);
                    piv_val_next  = mem_rdata;
                    found_next    = 1'b1;
                    pos_next      = last_idx;
                    mem_req.raddr = last_idx;
                    state_next    = ST_FSCAN;
                end else begin
                    hold_next = mem_rdata;
                    if (pos_reg == idx_t'(1)) begin
                        pos_next   = '0;
                        state_next = ST_ERD;
                    end else begin
                        pos_next      = pos_reg - idx_t'(1);
                        mem_req.raddr = pos_reg - idx_t'(2);
                    end
                end
            end
            ST_FSCAN: begin
                // rightmost element larger than the pivot; always found
                if (cmp_lt) begin
                    hold_next  = mem_rdata;
                    state_next = ST_WPIV;
                end else begin
                    pos_next      = pos_reg - idx_t'(1);
                    mem_req.raddr = pos_reg - idx_t'(1);
                end
            end
            ST_WPIV: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = piv_idx_reg;
                mem_req.wdata = hold_reg;
                state_next    = ST_WSUC;
            end
            ST_WSUC: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = pos_reg;
                mem_req.wdata = piv_val_reg;
                pos_next      = piv_idx_reg + idx_t'(1);
                hi_next       = last_idx;
                state_next    = ST_RCHK;
            end
            ST_RCHK: begin
                if (pos_reg < hi_reg) begin
                    mem_req.raddr = pos_reg;
                    state_next    = ST_RHI;
                end else begin
                    pos_next   = '0;
                    state_next = ST_ERD;
                end
            end
            ST_RHI: begin
                // mem_rdata is the low element here
                hold_next     = mem_rdata;
                mem_req.raddr = hi_reg;
                state_next    = ST_RLOV;
            end
            ST_RLOV: begin
                // keep the high element on the read port for the low write
                mem_req.raddr = hi_reg;
                state_next    = ST_RWLO;
            end
            ST_RWLO: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = pos_reg;
                mem_req.wdata = mem_rdata;
                state_next    = ST_RWHI;
            end
            ST_RWHI: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = hi_reg;
                mem_req.wdata = hold_reg;
                pos_next      = pos_reg + idx_t'(1);
                hi_next       = hi_reg - idx_t'(1);
                state_next    = ST_RCHK;
            end
            ST_ERD: begin
                state_next = ST_ELD;
            end
            ST_ELD: begin
                if (out_free) begin
                    out_req.ld = 1'b1;
                    if (emit_last) begin
                        cnt_next   = '0;
                        state_next = ST_LOAD;
                    end else begin
                        // prefetch the next element, one per cycle while the output register is free
                        pos_next      = pos_reg + idx_t'(1);
                        mem_req.raddr = pos_reg + idx_t'(1);
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            found_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg     <= pos_next;
        hi_reg      <= hi_next;
        piv_idx_reg <= piv_idx_next;
        piv_val_reg <= piv_val_next;
        hold_reg    <= hold_next;
    end

endmodule
